// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of line_edit_buffer.
// Uses the aclk / aresetn names of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

// ===== sv/leb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the line edit buffer.
// No dependencies; used by leb_cell, leb_cell_row and line_edit_buffer.
package leb_pkg;

    localparam int POS_W = 6;

    // key codes
    localparam logic [3:0] OP_START     = 4'd0;
    localparam logic [3:0] OP_PRELOAD   = 4'd1;
    localparam logic [3:0] OP_INSERT    = 4'd2;
    localparam logic [3:0] OP_ENTER     = 4'd3;
    localparam logic [3:0] OP_LEFT      = 4'd4;
    localparam logic [3:0] OP_RIGHT     = 4'd5;
    localparam logic [3:0] OP_BACKSPACE = 4'd6;
    localparam logic [3:0] OP_DELETE    = 4'd7;
    localparam logic [3:0] OP_ESCAPE    = 4'd8;

    // result kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_ATTR   = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_CANCEL = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_LENGTH   = 2'd0;
    localparam logic [1:0] REG_TEXT_COLOR   = 2'd1;
    localparam logic [1:0] REG_START_COLUMN = 2'd2;
    localparam logic [1:0] REG_SCREEN_LINE  = 2'd3;

    localparam logic [7:0] CURSOR_FLIP = 8'h80;

    typedef enum logic [1:0] {
        SRC_LEFT,
        SRC_RIGHT,
        SRC_CHAR,
        SRC_ZERO
    } src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_ATTR,
        ST_PRELOAD_CHAR,
        ST_SHIFT_RIGHT,
        ST_PLACE_CHAR,
        ST_CURSOR_OFF,
        ST_CURSOR_ON,
        ST_SHIFT_LEFT,
        ST_BLANK,
        ST_END_ATTR,
        ST_END_FLAG
    } state_t;

    typedef struct packed {
        logic             wr_en;
        logic [POS_W-1:0] wr_pos;
        src_t             src;
        logic [7:0]       char_code;
    } cell_ctrl_t;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] value;
        logic       last;
    } out_item_t;

endpackage

// ===== sv/line_edit_buffer.sv =====
`timescale 1ns / 1ps
// line_edit_buffer: single-line editor engine (key events in, display writes out).
// Depends on leb_pkg, leb_cell_row (and leb_cell), assert_macros.svh.
//
// Usage:
//  - s_ channel: one key event per transaction (op, char_code). s_ready is high only
//    while the editor is idle; an accepted key is fully processed before the next.
//  - m_ channel: display write transactions (kind, column, row, value, last); last
//    marks the final transaction caused by a key. Keys with no effect give none.
//  - cfg_ channel: register writes (max_length, text_color, start_column,
//    screen_line) by index; always ready, write only while idle.
//  - Timing: one result per cycle from a single output register, while the receiver
//    takes them. A key gives up to 62 results, set by the tail shift which moves one
//    cell of the chain per result; an ignored key is accepted and gives no result.
//  - Receiver stall: m_valid holds with stable data; the sequencer waits and
//    resumes when the register is taken, so nothing is lost.
//  - Reset: length and cursor go to 0, registers to their defaults; the cell
//    contents are undefined until written and need no clearing pass.
`include "assert_macros.svh"
module line_edit_buffer #(
    parameter int LINE_CAPACITY = 60
) (
    input  logic               aclk,
    input  logic               aresetn,
    // key input
    input  logic               s_valid,
    output logic               s_ready,
    input  leb_pkg::in_item_t  s_data,
    // display writes
    output logic               m_valid,
    input  logic               m_ready,
    output leb_pkg::out_item_t m_data,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int POS_W = leb_pkg::POS_W;
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(LINE_CAPACITY);

    // configuration registers
    logic [POS_W-1:0] max_length_reg;
    logic [7:0]       text_color_reg;
    logic [7:0]       start_column_reg;
    logic [7:0]       screen_line_reg;

    // sequencer state
    leb_pkg::state_t  state_reg, state_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] cur_reg, cur_next;
    logic [POS_W-1:0] ptr_reg, ptr_next;     // cell being written in shifts
    logic [3:0]       op_reg, op_next;
    logic [7:0]       ch_reg, ch_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    leb_pkg::out_item_t m_data_reg, m_data_next;

    logic                s_accept;
    logic                emit_en;      // a result can be moved into the output register
    logic [POS_W-1:0]    limit;
    logic                has_room;
    logic                gap_follows;  // cursor+1 < length: at least one left shift
    leb_pkg::cell_ctrl_t cell_ctrl;
    logic [7:0]          cell_value;
    logic [1:0]          emit_kind;
    logic [POS_W-1:0]    emit_pos;
    logic [7:0]          emit_value;
    logic                emit_last;
    logic [7:0]          cursor_attr;

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == leb_pkg::ST_IDLE);
    assign s_accept    = s_valid && s_ready;
    assign emit_en     = (state_reg != leb_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign limit       = (max_length_reg > CAP_POS) ? CAP_POS : max_length_reg;
    assign has_room    = (len_reg < limit);
    assign gap_follows = (({1'b0, cur_reg} + 7'd1) < {1'b0, len_reg});
    assign cursor_attr = text_color_reg ^ leb_pkg::CURSOR_FLIP;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg   <= 6'd60;
            text_color_reg   <= 8'd7;
            start_column_reg <= 8'd0;
            screen_line_reg  <= 8'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                leb_pkg::REG_MAX_LENGTH:   max_length_reg   <= cfg_data[POS_W-1:0];
                leb_pkg::REG_TEXT_COLOR:   text_color_reg   <= cfg_data;
                leb_pkg::REG_START_COLUMN: start_column_reg <= cfg_data;
                default:                   screen_line_reg  <= cfg_data;
            endcase
        end
    end

    // line store: chain of cells
    leb_cell_row #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_row (
        .aclk    (aclk),
        .ctrl    (cell_ctrl),
        .wr_value(cell_value)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            leb_pkg::ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_data.op)
                        leb_pkg::OP_START: state_next = leb_pkg::ST_START_ATTR;
                        leb_pkg::OP_PRELOAD: begin
                            if (has_room) state_next = leb_pkg::ST_PRELOAD_CHAR;
                        end
                        leb_pkg::OP_INSERT: begin
                            if (has_room) begin
                                state_next = (len_reg != cur_reg) ? leb_pkg::ST_SHIFT_RIGHT
                                                                  : leb_pkg::ST_PLACE_CHAR;
                            end
                        end
                        leb_pkg::OP_ENTER,
                        leb_pkg::OP_ESCAPE: state_next = leb_pkg::ST_END_ATTR;
                        leb_pkg::OP_LEFT,
                        leb_pkg::OP_BACKSPACE: begin
                            if (cur_reg != '0) state_next = leb_pkg::ST_CURSOR_OFF;
                        end
                        leb_pkg::OP_RIGHT: begin
                            if (cur_reg != len_reg) state_next = leb_pkg::ST_CURSOR_OFF;
                        end
                        leb_pkg::OP_DELETE: begin
                            if (cur_reg != len_reg) begin
                                state_next = gap_follows ? leb_pkg::ST_SHIFT_LEFT
                                                         : leb_pkg::ST_BLANK;
                            end
                        end
                        default: state_next = leb_pkg::ST_IDLE;
                    endcase
                end
            end
            leb_pkg::ST_START_ATTR: if (emit_en) state_next = leb_pkg::ST_IDLE;
            leb_pkg::ST_PRELOAD_CHAR: if (emit_en) state_next = leb_pkg::ST_CURSOR_OFF;
            leb_pkg::ST_SHIFT_RIGHT: begin
                if (emit_en && (ptr_reg - 6'd1 == cur_reg)) begin
                    state_next = leb_pkg::ST_PLACE_CHAR;
                end
            end
            leb_pkg::ST_PLACE_CHAR: if (emit_en) state_next = leb_pkg::ST_CURSOR_OFF;
            leb_pkg::ST_CURSOR_OFF: if (emit_en) state_next = leb_pkg::ST_CURSOR_ON;
            leb_pkg::ST_CURSOR_ON: begin
                if (emit_en) begin
                    if (op_reg != leb_pkg::OP_BACKSPACE) begin
                        state_next = leb_pkg::ST_IDLE;
                    end else begin
                        state_next = gap_follows ? leb_pkg::ST_SHIFT_LEFT : leb_pkg::ST_BLANK;
                    end
                end
            end
            leb_pkg::ST_SHIFT_LEFT: begin
                if (emit_en && (({1'b0, ptr_reg} + 7'd2) >= {1'b0, len_reg})) begin
                    state_next = leb_pkg::ST_BLANK;
                end
            end
            leb_pkg::ST_BLANK:    if (emit_en) state_next = leb_pkg::ST_IDLE;
            leb_pkg::ST_END_ATTR: if (emit_en) state_next = leb_pkg::ST_END_FLAG;
            leb_pkg::ST_END_FLAG: if (emit_en) state_next = leb_pkg::ST_IDLE;
            default:              state_next = leb_pkg::ST_IDLE;
        endcase
    end

    // outputs: result fields, cell writes, length/cursor/pointer updates
    always_comb begin
        len_next  = len_reg;
        cur_next  = cur_reg;
        ptr_next  = ptr_reg;
        op_next   = op_reg;
        ch_next   = ch_reg;

        emit_kind  = leb_pkg::KIND_CHAR;
        emit_pos   = cur_reg;
        emit_value = cell_value;
        emit_last  = 1'b0;

        cell_ctrl.wr_en     = 1'b0;
        cell_ctrl.wr_pos    = ptr_reg;
        cell_ctrl.src       = leb_pkg::SRC_ZERO;
        cell_ctrl.char_code = ch_reg;

        unique case (state_reg)
            leb_pkg::ST_IDLE: begin
                if (s_accept) begin
                    op_next = s_data.op;
                    ch_next = s_data.char_code;
                    // insert shifts from the end down, delete from the cursor up
                    ptr_next = (s_data.op == leb_pkg::OP_INSERT) ? len_reg : cur_reg;
                end
            end
            leb_pkg::ST_START_ATTR: begin
                emit_kind  = leb_pkg::KIND_ATTR;
                emit_pos   = '0;
                emit_value = cursor_attr;
                emit_last  = 1'b1;
                if (emit_en) begin
                    len_next = '0;
                    cur_next = '0;
                end
            end
            leb_pkg::ST_PRELOAD_CHAR: begin
                emit_pos         = len_reg;
                cell_ctrl.wr_pos = len_reg;
                cell_ctrl.src    = leb_pkg::SRC_CHAR;
                cell_ctrl.wr_en  = emit_en;
                if (emit_en) len_next = len_reg + 6'd1;
            end
            leb_pkg::ST_SHIFT_RIGHT: begin
                emit_pos        = ptr_reg;
                cell_ctrl.src   = leb_pkg::SRC_LEFT;
                cell_ctrl.wr_en = emit_en;
                if (emit_en) ptr_next = ptr_reg - 6'd1;
            end
            leb_pkg::ST_PLACE_CHAR: begin
                emit_pos         = cur_reg;
                cell_ctrl.wr_pos = cur_reg;
                cell_ctrl.src    = leb_pkg::SRC_CHAR;
                cell_ctrl.wr_en  = emit_en;
                if (emit_en) len_next = len_reg + 6'd1;
            end
            leb_pkg::ST_CURSOR_OFF: begin
                emit_kind  = leb_pkg::KIND_ATTR;
                emit_value = text_color_reg;
                if (emit_en) begin
                    if (op_reg == leb_pkg::OP_PRELOAD) begin
                        cur_next = len_reg;
                    end else if (op_reg == leb_pkg::OP_LEFT
                                 || op_reg == leb_pkg::OP_BACKSPACE) begin
                        cur_next = cur_reg - 6'd1;
                    end else begin
                        cur_next = cur_reg + 6'd1;
                    end
                end
            end
            leb_pkg::ST_CURSOR_ON: begin
                emit_kind  = leb_pkg::KIND_ATTR;
                emit_value = cursor_attr;
                emit_last  = (op_reg != leb_pkg::OP_BACKSPACE);
                if (emit_en) ptr_next = cur_reg;
            end
            leb_pkg::ST_SHIFT_LEFT: begin
                emit_pos        = ptr_reg;
                cell_ctrl.src   = leb_pkg::SRC_RIGHT;
                cell_ctrl.wr_en = emit_en;
                if (emit_en) ptr_next = ptr_reg + 6'd1;
            end
            leb_pkg::ST_BLANK: begin
                emit_pos         = len_reg - 6'd1;
                emit_last        = 1'b1;
                cell_ctrl.wr_pos = len_reg - 6'd1;
                cell_ctrl.src    = leb_pkg::SRC_ZERO;
                cell_ctrl.wr_en  = emit_en;
                if (emit_en) len_next = len_reg - 6'd1;
            end
            leb_pkg::ST_END_ATTR: begin
                emit_kind  = leb_pkg::KIND_ATTR;
                emit_value = text_color_reg;
            end
            leb_pkg::ST_END_FLAG: begin
                emit_kind  = (op_reg == leb_pkg::OP_ENTER) ? leb_pkg::KIND_ACCEPT
                                                           : leb_pkg::KIND_CANCEL;
                emit_value = 8'h00;
                emit_last  = 1'b1;
            end
            default: begin
                emit_last = 1'b0;
            end
        endcase
    end

    // output register: loaded when empty or being drained
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit_en) begin
            m_valid_next       = 1'b1;
            m_data_next.kind   = emit_kind;
            m_data_next.column = start_column_reg + {2'b00, emit_pos};
            m_data_next.row    = screen_line_reg;
            m_data_next.value  = emit_value;
            m_data_next.last   = emit_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= leb_pkg::ST_IDLE;
            len_reg     <= '0;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        op_reg     <= op_next;
        ch_reg     <= ch_next;
        m_data_reg <= m_data_next;
    end

    // checks
    `ASSERT_ALWAYS(a_cursor_in_line, cur_reg <= len_reg, "cursor beyond line end")
    `ASSERT_ALWAYS(a_length_in_capacity, len_reg <= CAP_POS, "line length exceeds capacity")
    `ASSERT_IMPLY(a_last_ends_key, emit_en && emit_last, state_reg == leb_pkg::ST_IDLE,
        "sequencer busy after final transaction")
    `ASSERT_IMPLY(a_stall_holds, m_valid && !m_ready && !emit_en, m_valid && $stable(m_data),
        "stalled result changed")

endmodule

// ===== sv/leb_cell.sv =====
`timescale 1ns / 1ps
// One character cell of the line store.
// Depends on leb_pkg (cell_ctrl_t, src_t, POS_W).
module leb_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                aclk,
    input  leb_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          left_in,
    input  logic [7:0]          right_in,
    output logic [7:0]          char_out,
    output logic [7:0]          hit_data
);

    logic [7:0] char_reg;
    logic [7:0] wr_data;
    logic       hit;

    assign hit = (ctrl.wr_pos == leb_pkg::POS_W'(CELL_INDEX));

    always_comb begin
        unique case (ctrl.src)
            leb_pkg::SRC_LEFT:  wr_data = left_in;
            leb_pkg::SRC_RIGHT: wr_data = right_in;
            leb_pkg::SRC_CHAR:  wr_data = ctrl.char_code;
            default:            wr_data = 8'h00;
        endcase
    end

    // addressed cell drives the value it is about to take
    assign hit_data = hit ? wr_data : 8'h00;
    assign char_out = char_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en && hit) begin
            char_reg <= wr_data;
        end
    end

endmodule

// ===== sv/leb_cell_row.sv =====
`timescale 1ns / 1ps
// Row of leb_cell instances wired to their neighbors, plus the write-data gather.
// Depends on leb_pkg and leb_cell.
module leb_cell_row #(
    parameter int LINE_CAPACITY = 60
) (
    input  logic                aclk,
    input  leb_pkg::cell_ctrl_t ctrl,
    output logic [7:0]          wr_value
);

    logic [7:0] cell_q   [LINE_CAPACITY];
    logic [7:0] cell_hit [LINE_CAPACITY];

    for (genvar i = 0; i < LINE_CAPACITY; i++) begin : g_cell
        logic [7:0] left_w;
        logic [7:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = 8'h00;
        end else begin : g_mid_l
            assign left_w = cell_q[i-1];
        end

        if (i == LINE_CAPACITY - 1) begin : g_last
            assign right_w = 8'h00;
        end else begin : g_mid_r
            assign right_w = cell_q[i+1];
        end

        leb_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .left_in (left_w),
            .right_in(right_w),
            .char_out(cell_q[i]),
            .hit_data(cell_hit[i])
        );
    end

    // at most one cell is addressed; OR of the gated contributions
    always_comb begin
        wr_value = 8'h00;
        for (int i = 0; i < LINE_CAPACITY; i++) begin
            wr_value = wr_value | cell_hit[i];
        end
    end

endmodule
